[sv/sfmd_pkg.sv]
// Shared types and constants of the signed fixed-point multiply-divide unit.
`default_nettype none
package sfmd_pkg;

   // Command codes carried in req_tuser
   localparam logic [1:0] CMD_MUL_DIV = 2'd0;
   localparam logic [1:0] CMD_DEG_RAD = 2'd1;
   localparam logic [1:0] CMD_RAD_DEG = 2'd2;

   // Angle conversion ratio, pi taken as 355/113
   localparam int CONST_BITS = 13;
   localparam logic [CONST_BITS-1:0] DEG_NUM = 13'd71;
   localparam logic [CONST_BITS-1:0] DEG_DEN = 13'd4068;

   // Per-request control that travels beside the data
   typedef struct packed {
      logic neg;       // result sign
      logic div_zero;  // divisor was zero
      logic kill;      // force a zero quotient with no overflow
   } ctl_type;

endpackage
`default_nettype wire

[sv/signed_fixed_mul_div.sv]
// Top level of the signed Q16.16 multiply-divide unit.
//
//  channel  direction  ports                         contents
//  req      in         req_tvalid/tready/tdata/tuser operands a, b, c; command
//  rsp      out        rsp_tvalid/tready/tdata/tuser quotient; zero-divide, overflow
//
// Throughput is one request per cycle while no result is held; the path runs
// through two front stages, one divider cell per dividend bit, and the
// output register. The row of divider cells sets the latency.
// Reset clears only the valid bits. A held result stalls the whole row,
// and req_tready drops in the same cycle.
`default_nettype none
module signed_fixed_mul_div #(
   parameter int WORD_BITS = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [95:0]  req_tdata,   // operand_a [31:0], operand_b [63:32], operand_c [95:64]
   input  wire [1:0]   req_tuser,   // command [1:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // quotient [31:0]
   output logic [1:0]  rsp_tuser    // divide_by_zero [0], overflowed [1]
);

   localparam int Cells = 2 * WORD_BITS;

   logic en;

   logic                   front_valid;
   logic [2*WORD_BITS-1:0] front_product;
   logic [WORD_BITS-1:0]   front_divisor;
   sfmd_pkg::ctl_type      front_ctl;

   logic                   ch_valid    [0:Cells];
   logic [2*WORD_BITS-1:0] ch_dividend [0:Cells];
   logic [WORD_BITS-1:0]   ch_rem      [0:Cells];
   logic [WORD_BITS-1:0]   ch_divisor  [0:Cells];
   logic [WORD_BITS-1:0]   ch_quot     [0:Cells];
   logic                   ch_high     [0:Cells];
   sfmd_pkg::ctl_type      ch_ctl      [0:Cells];

   logic [WORD_BITS-1:0] q_low, q_signed;
   logic                 ovf;
   logic [31:0]          quot_in;
   logic [1:0]           flags_in;

   logic        rsp_valid_ff;
   logic [31:0] quot_ff;
   logic [1:0]  flags_ff;

   // Advance the whole row unless a result is held
   assign en         = ~rsp_valid_ff | rsp_tready;
   assign req_tready = en;

   sfmd_front #(.WORD_BITS(WORD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .command   (req_tuser),
      .operand_a (req_tdata[WORD_BITS-1:0]),
      .operand_b (req_tdata[32+WORD_BITS-1:32]),
      .operand_c (req_tdata[64+WORD_BITS-1:64]),
      .out_valid (front_valid),
      .product   (front_product),
      .divisor   (front_divisor),
      .ctl       (front_ctl)
   );

   // Seed the divider row
   assign ch_valid[0]    = front_valid;
   assign ch_dividend[0] = front_product;
   assign ch_rem[0]      = '0;
   assign ch_divisor[0]  = front_divisor;
   assign ch_quot[0]     = '0;
   assign ch_high[0]     = 1'b0;
   assign ch_ctl[0]      = front_ctl;

   for (genvar i = 0; i < Cells; i++) begin : g_cell
      sfmd_cell #(.WORD_BITS(WORD_BITS)) u_cell (
         .clock        (clock),
         .reset        (reset),
         .en           (en),
         .in_valid     (ch_valid[i]),
         .in_dividend  (ch_dividend[i]),
         .in_rem       (ch_rem[i]),
         .in_divisor   (ch_divisor[i]),
         .in_quot      (ch_quot[i]),
         .in_high      (ch_high[i]),
         .in_ctl       (ch_ctl[i]),
         .out_valid    (ch_valid[i+1]),
         .out_dividend (ch_dividend[i+1]),
         .out_rem      (ch_rem[i+1]),
         .out_divisor  (ch_divisor[i+1]),
         .out_quot     (ch_quot[i+1]),
         .out_high     (ch_high[i+1]),
         .out_ctl      (ch_ctl[i+1])
      );
   end

   // Apply sign, detect overflow, sign-extend to the port width; kill forces zero
   always_comb begin
      q_low    = ch_quot[Cells];
      q_signed = ch_ctl[Cells].neg ? (~q_low + 1'b1) : q_low;
      ovf      = ch_high[Cells]
               | (q_low[WORD_BITS-1]
                  & (~ch_ctl[Cells].neg | (q_low[WORD_BITS-2:0] != '0)));
      if (ch_ctl[Cells].kill) begin
         quot_in = '0;
         ovf     = 1'b0;
      end else begin
         quot_in = 32'(signed'(q_signed));
      end
      flags_in = {ovf, ch_ctl[Cells].div_zero};
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ch_valid[Cells];
      end
      if (en) begin
         quot_ff  <= quot_in;
         flags_ff <= flags_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = quot_ff;
   assign rsp_tuser  = flags_ff;

endmodule
`default_nettype wire

[sv/sfmd_front.sv]
// Operand magnitudes, constant selection and the magnitude product.
`default_nettype none
module sfmd_front #(
   parameter int WORD_BITS = 32
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       en,
   input  wire                       in_valid,
   input  wire [1:0]                 command,
   input  wire [WORD_BITS-1:0]       operand_a,
   input  wire [WORD_BITS-1:0]       operand_b,
   input  wire [WORD_BITS-1:0]       operand_c,
   output logic                      out_valid,
   output logic [2*WORD_BITS-1:0]    product,
   output logic [WORD_BITS-1:0]      divisor,
   output sfmd_pkg::ctl_type         ctl
);

   localparam int PadBits = WORD_BITS - sfmd_pkg::CONST_BITS;

   logic [WORD_BITS-1:0] mag_a, mag_b, mag_c;
   logic                 neg_a, neg_b, neg_c;
   logic [WORD_BITS-1:0] mul_b, div_d;
   sfmd_pkg::ctl_type    ctl_sel;

   logic                 valid_a_ff;
   logic [WORD_BITS-1:0] ma_ff, mb_ff, md_a_ff;
   sfmd_pkg::ctl_type    ctl_a_ff;

   logic                    valid_b_ff;
   logic [2*WORD_BITS-1:0]  prod_ff;
   logic [WORD_BITS-1:0]    md_b_ff;
   sfmd_pkg::ctl_type       ctl_b_ff;

   // Take magnitudes by two's-complement negation
   always_comb begin
      neg_a = operand_a[WORD_BITS-1];
      neg_b = operand_b[WORD_BITS-1];
      neg_c = operand_c[WORD_BITS-1];
      mag_a = neg_a ? (~operand_a + 1'b1) : operand_a;
      mag_b = neg_b ? (~operand_b + 1'b1) : operand_b;
      mag_c = neg_c ? (~operand_c + 1'b1) : operand_c;
   end

   // Pick multiplier, divisor and sign by command
   always_comb begin
      mul_b   = mag_b;
      div_d   = mag_c;
      ctl_sel = '0;
      case (command)
         sfmd_pkg::CMD_MUL_DIV: begin
            ctl_sel.neg      = neg_a ^ neg_b ^ neg_c;
            ctl_sel.div_zero = (mag_c == '0);
            ctl_sel.kill     = (mag_c == '0);
            // keep the divider fed with a harmless value
            if (mag_c == '0) begin
               div_d = {{(WORD_BITS-1){1'b0}}, 1'b1};
            end
         end
         sfmd_pkg::CMD_DEG_RAD: begin
            ctl_sel.neg = neg_a;
            mul_b = {{PadBits{1'b0}}, sfmd_pkg::DEG_NUM};
            div_d = {{PadBits{1'b0}}, sfmd_pkg::DEG_DEN};
         end
         sfmd_pkg::CMD_RAD_DEG: begin
            ctl_sel.neg = neg_a;
            mul_b = {{PadBits{1'b0}}, sfmd_pkg::DEG_DEN};
            div_d = {{PadBits{1'b0}}, sfmd_pkg::DEG_NUM};
         end
         default: begin
            ctl_sel.kill = 1'b1;
            div_d = {{(WORD_BITS-1){1'b0}}, 1'b1};
         end
      endcase
   end

   // Stage A: hold selected operands
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (en) begin
         valid_a_ff <= in_valid;
      end
      if (en) begin
         ma_ff   <= mag_a;
         mb_ff   <= mul_b;
         md_a_ff <= div_d;
         ctl_a_ff <= ctl_sel;
      end
   end

   // Stage B: register the full product
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (en) begin
         valid_b_ff <= valid_a_ff;
      end
      if (en) begin
         prod_ff  <= {{WORD_BITS{1'b0}}, ma_ff} * {{WORD_BITS{1'b0}}, mb_ff};
         md_b_ff  <= md_a_ff;
         ctl_b_ff <= ctl_a_ff;
      end
   end

   assign out_valid = valid_b_ff;
   assign product   = prod_ff;
   assign divisor   = md_b_ff;
   assign ctl       = ctl_b_ff;

endmodule
`default_nettype wire

[sv/sfmd_cell.sv]
// One restoring-division cell: develops one quotient bit per request.
`default_nettype none
module sfmd_cell #(
   parameter int WORD_BITS = 32
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     en,
   input  wire                     in_valid,
   input  wire [2*WORD_BITS-1:0]   in_dividend,
   input  wire [WORD_BITS-1:0]     in_rem,
   input  wire [WORD_BITS-1:0]     in_divisor,
   input  wire [WORD_BITS-1:0]     in_quot,
   input  wire                     in_high,
   input  sfmd_pkg::ctl_type       in_ctl,
   output logic                    out_valid,
   output logic [2*WORD_BITS-1:0]  out_dividend,
   output logic [WORD_BITS-1:0]    out_rem,
   output logic [WORD_BITS-1:0]    out_divisor,
   output logic [WORD_BITS-1:0]    out_quot,
   output logic                    out_high,
   output sfmd_pkg::ctl_type       out_ctl
);

   logic [WORD_BITS:0]   trial;
   logic [WORD_BITS+1:0] diff;
   logic                 qbit;

   logic                    valid_ff;
   logic [2*WORD_BITS-1:0]  dividend_ff, dividend_in;
   logic [WORD_BITS-1:0]    rem_ff, rem_in;
   logic [WORD_BITS-1:0]    divisor_ff;
   logic [WORD_BITS-1:0]    quot_ff, quot_in;
   logic                    high_ff, high_in;
   sfmd_pkg::ctl_type       ctl_ff;

   // Bring down the next dividend bit and try to subtract
   always_comb begin
      trial       = {in_rem, in_dividend[2*WORD_BITS-1]};
      diff        = {1'b0, trial} - {2'b00, in_divisor};
      qbit        = ~diff[WORD_BITS+1];
      rem_in      = qbit ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
      dividend_in = {in_dividend[2*WORD_BITS-2:0], 1'b0};
      quot_in     = {in_quot[WORD_BITS-2:0], qbit};
      // a bit leaving the low word means the quotient is too wide
      high_in     = in_high | in_quot[WORD_BITS-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         dividend_ff <= dividend_in;
         rem_ff      <= rem_in;
         divisor_ff  <= in_divisor;
         quot_ff     <= quot_in;
         high_ff     <= high_in;
         ctl_ff      <= in_ctl;
      end
   end

   assign out_valid    = valid_ff;
   assign out_dividend = dividend_ff;
   assign out_rem      = rem_ff;
   assign out_divisor  = divisor_ff;
   assign out_quot     = quot_ff;
   assign out_high     = high_ff;
   assign out_ctl      = ctl_ff;

endmodule
`default_nettype wire

[bench/tb_signed_fixed_mul_div.sv]
// Self-checking bench for the signed Q16.16 multiply-divide unit.
`timescale 1ns / 100ps

// Command code left unused by the unit
localparam logic [1:0] CMD_UNUSED = 2'd3;

typedef struct packed {
   logic [31:0] quotient;
   logic        divide_by_zero;
   logic        overflowed;
} quotient_result_type;

typedef struct packed {
   logic [1:0]          command;
   quotient_result_type result;
} awaited_quotient_type;

class quotient_scoreboard;
   awaited_quotient_type awaited_quotients[$];
   int errors = 0;
   int checked = 0;
   int zero_divides = 0;
   int overflows = 0;
   int per_command[4] = '{default: 0};

   // Compute the signed truncated quotient of one request at 32-bit words
   function quotient_result_type compute_quotient(logic [1:0] command, logic [31:0] a,
                                                  logic [31:0] b, logic [31:0] c);
      quotient_result_type r;
      logic [63:0] mag_a, mag_b, mag_c, num, den, q, limit;
      logic neg, active;
      r = '0;
      mag_a = {32'd0, a[31] ? -a : a};
      mag_b = {32'd0, b[31] ? -b : b};
      mag_c = {32'd0, c[31] ? -c : c};
      active = 1'b0;
      neg = 1'b0;
      num = '0;
      den = 64'd1;
      case (command)
         sfmd_pkg::CMD_MUL_DIV: begin
            if (mag_c == 0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               active = 1'b1;
               neg = a[31] ^ b[31] ^ c[31];
               num = mag_a * mag_b;
               den = mag_c;
            end
         end
         sfmd_pkg::CMD_DEG_RAD: begin
            active = 1'b1;
            neg = a[31];
            num = mag_a * 64'(sfmd_pkg::DEG_NUM);
            den = 64'(sfmd_pkg::DEG_DEN);
         end
         sfmd_pkg::CMD_RAD_DEG: begin
            active = 1'b1;
            neg = a[31];
            num = mag_a * 64'(sfmd_pkg::DEG_DEN);
            den = 64'(sfmd_pkg::DEG_NUM);
         end
         default: begin
            // unused command yields zero with both flags clear
            active = 1'b0;
         end
      endcase
      if (active) begin
         q = num / den;
         limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
         r.quotient = neg ? -q[31:0] : q[31:0];
         r.overflowed = (q > limit);
      end
      return r;
   endfunction

   // Note an accepted request and queue its predicted result
   function void note_request(logic [1:0] command, logic [31:0] a, logic [31:0] b,
                              logic [31:0] c);
      awaited_quotient_type entry;
      entry.command = command;
      entry.result = compute_quotient(command, a, b, c);
      awaited_quotients.push_back(entry);
   endfunction

   task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch #%0d at %0t: %s got %h, wanted %h", errors + 1, $realtime,
               what, got, want);
      errors++;
   endtask

   // Compare an accepted result with the oldest prediction
   task check_response(logic [31:0] data, logic [1:0] user);
      awaited_quotient_type entry;
      if (awaited_quotients.size() == 0) begin
         report_mismatch("result with no request waiting, quotient", data, 32'd0);
      end else begin
         entry = awaited_quotients.pop_front();
         if (data !== entry.result.quotient)
            report_mismatch("quotient", data, entry.result.quotient);
         if (user[0] !== entry.result.divide_by_zero)
            report_mismatch("divide_by_zero", {31'd0, user[0]},
                            {31'd0, entry.result.divide_by_zero});
         if (user[1] !== entry.result.overflowed)
            report_mismatch("overflowed", {31'd0, user[1]},
                            {31'd0, entry.result.overflowed});
         checked++;
         per_command[entry.command]++;
         if (entry.result.divide_by_zero) zero_divides++;
         if (entry.result.overflowed) overflows++;
      end
   endtask

   function int pending();
      return awaited_quotients.size();
   endfunction
endclass

module tb_signed_fixed_mul_div;

   localparam int ITEMS_PER_PHASE = 310;
   localparam int PHASES = 5;
   localparam int SETTLE_CYCLES = 80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;   // operand_a [31:0], operand_b [63:32], operand_c [95:64]
   logic [1:0]  req_tuser = '0;   // command [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // quotient [31:0]
   logic [1:0]  rsp_tuser;        // divide_by_zero [0], overflowed [1]

   // Set to run both sides without idle cycles
   logic        steady = 1'b0;

   quotient_scoreboard board = new();

   signed_fixed_mul_div uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watch both channels at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_request(req_tuser, req_tdata[31:0], req_tdata[63:32],
                               req_tdata[95:64]);
         if (rsp_tvalid && rsp_tready)
            board.check_response(rsp_tdata, rsp_tuser);
      end
   end

   // Stall the result channel a random number of cycles before each result
   initial begin
      int stall;
      wait (reset == 1'b0);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Offer one request after a random gap and hold it until accepted
   task send_request(logic [1:0] command, logic [31:0] a, logic [31:0] b,
                     logic [31:0] c);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {c, b, a};
      req_tuser <= command;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Hold off the sender until every predicted result has arrived
   task wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Mix of zero, extremes, small integers, moderate Q16.16 values and full words
   function logic [31:0] pick_operand();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0: v = 32'd0;
         1: begin
            case ($urandom_range(0, 3))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'hFFFF_FFFF;
               default: v = 32'd1;
            endcase
         end
         2, 3: v = 32'($urandom_range(0, 2000)) - 32'd1000;
         4, 5: v = 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function logic [1:0] pick_command();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return CMD_UNUSED;
      case (r % 3)
         0: return sfmd_pkg::CMD_MUL_DIV;
         1: return sfmd_pkg::CMD_DEG_RAD;
         default: return sfmd_pkg::CMD_RAD_DEG;
      endcase
   endfunction

   initial begin
      logic [31:0] divisor;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, truncation, signs, zero divisor, both conversions
      send_request(sfmd_pkg::CMD_MUL_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
      send_request(sfmd_pkg::CMD_MUL_DIV, 32'h8000_0000, 32'h8000_0000, 32'd1);
      send_request(sfmd_pkg::CMD_MUL_DIV, 32'h8000_0000, 32'd1, 32'd1);
      send_request(sfmd_pkg::CMD_MUL_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1);
      send_request(sfmd_pkg::CMD_MUL_DIV, 32'd5, 32'd7, 32'd0);
      send_request(sfmd_pkg::CMD_MUL_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
      send_request(sfmd_pkg::CMD_MUL_DIV, 32'd0, -32'd5, 32'd3);
      send_request(sfmd_pkg::CMD_MUL_DIV, -32'd7, 32'd3, 32'd2);
      send_request(sfmd_pkg::CMD_MUL_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_request(sfmd_pkg::CMD_MUL_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(sfmd_pkg::CMD_MUL_DIV, 32'h1234_5678, 32'd3, 32'hFFFF_FFFF);
      send_request(sfmd_pkg::CMD_MUL_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_request(sfmd_pkg::CMD_DEG_RAD, 32'd0, 32'd0, 32'd0);
      send_request(sfmd_pkg::CMD_DEG_RAD, 32'h7FFF_FFFF, 32'd0, 32'd0);
      send_request(sfmd_pkg::CMD_DEG_RAD, 32'h8000_0000, 32'd0, 32'd0);
      send_request(sfmd_pkg::CMD_DEG_RAD, 32'hFFFF_FFFF, 32'd0, 32'd0);
      send_request(sfmd_pkg::CMD_DEG_RAD, 32'h00B4_0000, 32'hFFFF_FFFF, 32'h8000_0000);
      send_request(sfmd_pkg::CMD_RAD_DEG, 32'h7FFF_FFFF, 32'd0, 32'd0);
      send_request(sfmd_pkg::CMD_RAD_DEG, 32'h8000_0000, 32'd0, 32'd0);
      send_request(sfmd_pkg::CMD_RAD_DEG, 32'd71, 32'd0, 32'd0);
      send_request(sfmd_pkg::CMD_RAD_DEG, -32'd71, 32'd0, 32'd0);
      send_request(sfmd_pkg::CMD_RAD_DEG, 32'd0, 32'h8000_0000, 32'd0);
      send_request(sfmd_pkg::CMD_RAD_DEG, 32'h0003_243F, 32'd0, 32'd0);
      send_request(CMD_UNUSED, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
      send_request(CMD_UNUSED, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
      wait_for_drain();

      // Random phases, one of them with no idling on either side
      for (int phase = 0; phase < PHASES; phase++) begin
         steady = (phase == 2);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            divisor = ($urandom_range(0, 15) == 0) ? 32'd0 : pick_operand();
            send_request(pick_command(), pick_operand(), pick_operand(), divisor);
         end
         wait_for_drain();
      end
      steady = 1'b0;

      // Let any stray result surface before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.pending() != 0)
         board.report_mismatch("results still missing, count", board.pending(), 32'd0);

      $display("Checked %0d results: %0d multiply-divide, %0d deg-to-rad, %0d rad-to-deg,",
               board.checked, board.per_command[sfmd_pkg::CMD_MUL_DIV],
               board.per_command[sfmd_pkg::CMD_DEG_RAD],
               board.per_command[sfmd_pkg::CMD_RAD_DEG]);
      $display("%0d unused-command, %0d zero divisors, %0d overflows, %0d mismatches.",
               board.per_command[CMD_UNUSED], board.zero_divides, board.overflows,
               board.errors);
      if (board.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
